>>> hdl/stb_pkg.sv
// Shared constants, types and codes of the software timer bank.
package stb_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OP_W    = 3;
    localparam int TASK_W  = 7;
    localparam int EVENT_W = 16;
    localparam int COUNT_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_START   = 3'd0,
        OP_RESTART = 3'd1,
        OP_STOP    = 3'd2,
        OP_STATUS  = 3'd3,
        OP_TICK    = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               periodic;
        logic [TASK_W-1:0]  task_id;
        logic [EVENT_W-1:0] evt_id;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] limit;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

endpackage

>>> hdl/stb_in_if.sv
// Command channel of the software timer bank.
interface stb_in_if;
    logic                        valid;
    logic                        ready;
    logic [stb_pkg::OP_W-1:0]    op;
    logic [stb_pkg::TASK_W-1:0]  task_id;
    logic [stb_pkg::EVENT_W-1:0] evt_id;
    logic [stb_pkg::COUNT_W-1:0] timeout;
    logic                        periodic;

    modport source (output valid, op, task_id, evt_id, timeout, periodic, input ready);
    modport sink (input valid, op, task_id, evt_id, timeout, periodic, output ready);
endinterface

>>> hdl/stb_out_if.sv
// Result channel of the software timer bank.
interface stb_out_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic                        ok;
    logic [stb_pkg::TASK_W-1:0]  fired_task;
    logic [stb_pkg::EVENT_W-1:0] fired_event;
    logic                        last;

    modport source (output valid, kind, ok, fired_task, fired_event, last, input ready);
    modport sink (input valid, kind, ok, fired_task, fired_event, last, output ready);
endinterface

>>> hdl/stb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module stb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    i_clk,
    i_we,
    i_waddr,
    i_wdata,
    i_raddr,
    o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             i_clk;
    input  logic             i_we;
    input  logic [AW-1:0]    i_waddr;
    input  logic [WIDTH-1:0] i_wdata;
    input  logic [AW-1:0]    i_raddr;
    output logic [WIDTH-1:0] o_rdata;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/software_timer_bank.sv
// Software timer bank: slot table in RAM, scanned one slot per cycle unless a tick stalls on the receiver.
//
// Commands enter on i_cmd (start, restart, stop, status, tick); results
// leave on o_res through an output register, so a new item is taken while a
// result still waits. Every command other than a tick gives one response
// with last set. A tick gives one expiry result per timer that fires, in slot
// order, the final one with last set, and none if no timer fires.
// Start and undefined ops go straight from idle to the done state and respond
// from there. Restart, stop and status read the slot RAM from slot zero on,
// one slot per cycle, and stop at the first active match. A tick reads every
// slot through the single read port of the slot RAM and updates and writes
// back every active one.
// A new item is taken only when the previous one has handed its last result
// to the output register. When the receiver stalls, a tick holds at the slot
// that needs to emit and re-reads it until the output register frees up.
// Reset clears all active bits at once; slot contents of free slots are never
// looked at, so the RAM needs no clearing pass and the block is ready right
// after reset.
module software_timer_bank (
    input  logic    i_clk,
    input  logic    i_rst_n,
    stb_in_if.sink  i_cmd,
    stb_out_if.source o_res
);
    import stb_pkg::*;

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [TASK_W-1:0]  r_task, n_task;
    logic [EVENT_W-1:0] r_event, n_event;
    logic [SLOT_W-1:0]  r_idx, n_idx;
    logic [SLOTS-1:0]   r_active, n_active;

    logic               r_pend_v, n_pend_v;
    logic               r_pend_kind, n_pend_kind;
    logic               r_pend_ok, n_pend_ok;
    logic [TASK_W-1:0]  r_pend_task, n_pend_task;
    logic [EVENT_W-1:0] r_pend_event, n_pend_event;

    logic               r_out_v, n_out_v;
    logic               r_out_kind, n_out_kind;
    logic               r_out_ok, n_out_ok;
    logic [TASK_W-1:0]  r_out_task, n_out_task;
    logic [EVENT_W-1:0] r_out_event, n_out_event;
    logic               r_out_last, n_out_last;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    t_slot                ram_wdata;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [SLOT_BITS-1:0] ram_rdata;
    t_slot                rd;

    logic              slot_act, tag_hit, fire, out_free, stall, is_last, scan_end;
    logic              free_v;
    logic [SLOT_W-1:0] free_idx;
    logic              push, push_last;
    t_op               in_op;

    stb_ram #(
        .WIDTH(SLOT_BITS),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd       = t_slot'(ram_rdata);
    assign in_op    = t_op'(i_cmd.op);
    assign slot_act = r_active[r_idx];
    assign tag_hit  = slot_act && (rd.task_id == r_task) && (rd.evt_id == r_event);
    assign fire     = (r_op == OP_TICK) && slot_act && (rd.count > rd.limit);
    assign out_free = !r_out_v || o_res.ready;
    assign stall    = fire && r_pend_v && !out_free;
    assign is_last  = (r_idx == SLOT_W'(SLOTS - 1));
    assign scan_end = !stall && (is_last || ((r_op != OP_TICK) && tag_hit));

    always_comb begin
        free_v   = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_v   = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    if (in_op == OP_TICK || in_op == OP_RESTART ||
                        in_op == OP_STOP || in_op == OP_STATUS) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_pend_v || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op         = r_op;
        n_task       = r_task;
        n_event      = r_event;
        n_idx        = r_idx;
        n_active     = r_active;
        n_pend_v     = r_pend_v;
        n_pend_kind  = r_pend_kind;
        n_pend_ok    = r_pend_ok;
        n_pend_task  = r_pend_task;
        n_pend_event = r_pend_event;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = rd;
        ram_raddr    = '0;
        push         = 1'b0;
        push_last    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op         = in_op;
                    n_task       = i_cmd.task_id;
                    n_event      = i_cmd.evt_id;
                    n_idx        = '0;
                    n_pend_v     = (in_op != OP_TICK);
                    n_pend_kind  = 1'b0;
                    n_pend_ok    = (in_op == OP_START) && free_v;
                    n_pend_task  = '0;
                    n_pend_event = '0;
                    if (in_op == OP_START && free_v) begin
                        ram_we             = 1'b1;
                        ram_waddr          = free_idx;
                        ram_wdata.periodic = i_cmd.periodic;
                        ram_wdata.task_id  = i_cmd.task_id;
                        ram_wdata.evt_id   = i_cmd.evt_id;
                        ram_wdata.count    = '0;
                        ram_wdata.limit    = i_cmd.timeout;
                        n_active[free_idx] = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                ram_raddr = (stall || is_last) ? r_idx : r_idx + SLOT_W'(1);
                n_idx     = ram_raddr;
                case (r_op)
                    OP_TICK: begin
                        if (slot_act && !stall) begin
                            ram_we          = 1'b1;
                            ram_wdata.count = rd.count + COUNT_W'(1);
                            if (fire) begin
                                if (rd.periodic) begin
                                    ram_wdata.count = '0;
                                end else begin
                                    n_active[r_idx] = 1'b0;
                                end
                                push         = r_pend_v;
                                n_pend_v     = 1'b1;
                                n_pend_kind  = 1'b1;
                                n_pend_ok    = 1'b1;
                                n_pend_task  = rd.task_id;
                                n_pend_event = rd.evt_id;
                            end
                        end
                    end
                    OP_RESTART: begin
                        if (tag_hit) begin
                            ram_we          = 1'b1;
                            ram_wdata.count = '0;
                            n_pend_ok       = 1'b1;
                        end
                    end
                    OP_STOP: begin
                        if (tag_hit) begin
                            ram_we          = 1'b1;
                            ram_wdata       = '0;
                            n_active[r_idx] = 1'b0;
                            n_pend_ok       = 1'b1;
                        end
                    end
                    OP_STATUS: begin
                        if (tag_hit) begin
                            n_pend_ok = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_DONE: begin
                if (r_pend_v && out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_pend_v  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_v     = r_out_v;
        n_out_kind  = r_out_kind;
        n_out_ok    = r_out_ok;
        n_out_task  = r_out_task;
        n_out_event = r_out_event;
        n_out_last  = r_out_last;
        if (push) begin
            n_out_v     = 1'b1;
            n_out_kind  = r_pend_kind;
            n_out_ok    = r_pend_ok;
            n_out_task  = r_pend_task;
            n_out_event = r_pend_event;
            n_out_last  = push_last;
        end else if (r_out_v && o_res.ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
        r_op         <= n_op;
        r_task       <= n_task;
        r_event      <= n_event;
        r_idx        <= n_idx;
        r_pend_kind  <= n_pend_kind;
        r_pend_ok    <= n_pend_ok;
        r_pend_task  <= n_pend_task;
        r_pend_event <= n_pend_event;
        r_out_kind   <= n_out_kind;
        r_out_ok     <= n_out_ok;
        r_out_task   <= n_out_task;
        r_out_event  <= n_out_event;
        r_out_last   <= n_out_last;
    end

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_v;
    assign o_res.kind        = r_out_kind;
    assign o_res.ok          = r_out_ok;
    assign o_res.fired_task  = r_out_task;
    assign o_res.fired_event = r_out_event;
    assign o_res.last        = r_out_last;
endmodule
